// ----- rtl/bclfu_pkg.sv -----
// shared types and constants for the block cache lfu controller
package bclfu_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_SYNC  = 2'd2;

    localparam logic [0:0] REG_WRITE_THROUGH = 1'd0;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request
        logic lookup;     // tag compare and free search
        logic min_pass;   // victim pass: minimum use count
        logic age_pass;   // victim pass: oldest among minimum
        logic commit;     // update entry and present result
        logic sync_start; // capture dirty mask
        logic sync_emit;  // present next dirty entry
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_sync;
        logic is_bad;
        logic hit;
        logic has_free;
        logic dirty_any;
        logic dirty_one;
    } t_sts;

endpackage

// ----- rtl/bclfu_ctrl.sv -----
// controller state machine of the block cache lfu controller
module bclfu_ctrl
    import bclfu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output logic o_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOOKUP = 7'b0000010,
        S_MIN    = 7'b0000100,
        S_AGE    = 7'b0001000,
        S_COMMIT = 7'b0010000,
        S_SYNC   = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_sync_out, n_sync_out;

    wire w_out_free = !i_out_stall;

    always_comb begin
        n_state    = r_state;
        n_sync_out = r_sync_out;
        o_cmd      = '0;
        o_stall    = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_sts.is_bad) begin
                    n_state = S_IDLE;
                end else if (i_sts.is_sync) begin
                    o_cmd.sync_start = 1'b1;
                    n_state = S_SYNC;
                end else begin
                    o_cmd.lookup = 1'b1;
                    n_state = S_MIN;
                end
            end
            S_MIN: begin
                if (i_sts.hit || i_sts.has_free) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.min_pass = 1'b1;
                    n_state = S_AGE;
                end
            end
            S_AGE: begin
                o_cmd.age_pass = 1'b1;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_sync_out   = 1'b0;
                n_state      = S_OUT;
            end
            S_SYNC: begin
                if (!i_sts.dirty_any) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.sync_emit = 1'b1;
                    n_sync_out = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = r_sync_out ? S_SYNC : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sync_out <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sync_out <= n_sync_out;
        end
    end

endmodule

// ----- rtl/bclfu_dp.sv -----
// tag, policy and result datapath of the block cache lfu controller
module bclfu_dp
    import bclfu_pkg::*;
#(
    parameter int ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_write_through,
    input  logic [1:0]  i_operation,
    input  logic        i_region,
    input  logic [31:0] i_block_number,
    input  logic [31:0] i_now_ms,
    output t_sts        o_sts,
    output logic [2:0]  o_slot,
    output logic        o_result_region,
    output logic        o_hit,
    output logic        o_fetch_needed,
    output logic        o_evict_dirty,
    output logic [31:0] o_evicted_block,
    output logic        o_disk_write,
    output logic [31:0] o_written_block,
    output logic [31:0] o_hits_total,
    output logic [31:0] o_misses_total,
    output logic        o_last
);

    localparam int N  = 2 * ENTRIES;
    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KW = $clog2(N);

    logic [31:0] r_tag   [N];
    logic [31:0] r_count [N];
    logic [31:0] r_time  [N];
    logic [N-1:0] r_valid, r_dirty;
    logic [31:0] r_hits, r_misses;

    logic [1:0]  r_op;
    logic        r_reg;
    logic [31:0] r_blk, r_now;
    logic        r_hit, r_free;
    logic [SW-1:0] r_slot;
    logic [31:0] r_least;
    logic [N-1:0] r_pend;

    // region view
    logic [ENTRIES-1:0] w_match, w_freev, w_eq;
    logic [31:0] w_min;
    logic [SW-1:0] w_hit_idx, w_free_idx, w_age_idx;
    logic [31:0] w_best_age;
    logic w_found;
    logic [KW-1:0] w_dk;

    function automatic logic [KW-1:0] kidx(input logic r, input logic [SW-1:0] s);
        logic [KW:0] t;
        t = {{KW{1'b0}}, r} * (KW+1)'(ENTRIES) + (KW+1)'(s);
        return t[KW-1:0];
    endfunction

    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            w_match[i] = r_valid[kidx(r_reg, SW'(i))] && r_tag[kidx(r_reg, SW'(i))] == r_blk;
            w_freev[i] = !r_valid[kidx(r_reg, SW'(i))];
            if (w_match[i]) w_hit_idx = SW'(i);
            if (w_freev[i]) w_free_idx = SW'(i);
        end
        w_min = 32'hFFFF_FFFF;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_count[kidx(r_reg, SW'(i))] < w_min) w_min = r_count[kidx(r_reg, SW'(i))];
        end
        w_age_idx  = '0;
        w_best_age = '0;
        w_found    = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_eq[i] = r_count[kidx(r_reg, SW'(i))] == r_least;
            if (w_eq[i] && (!w_found || (r_now - r_time[kidx(r_reg, SW'(i))]) > w_best_age))
            begin
                w_found    = 1'b1;
                w_best_age = r_now - r_time[kidx(r_reg, SW'(i))];
                w_age_idx  = SW'(i);
            end
        end
        w_dk = '0;
        for (int k = N - 1; k >= 0; k--) begin
            if (r_pend[k]) w_dk = KW'(k);
        end
    end

    assign o_sts.is_sync   = (r_op == OP_SYNC);
    assign o_sts.is_bad    = (r_op != OP_READ) && (r_op != OP_WRITE) && (r_op != OP_SYNC);
    assign o_sts.hit       = r_hit;
    assign o_sts.has_free  = r_free;
    assign o_sts.dirty_any = |r_pend;
    assign o_sts.dirty_one = $onehot(r_pend);

    wire w_wr = (r_op == OP_WRITE);
    logic [KW-1:0] w_k;
    assign w_k = kidx(r_reg, r_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_dirty  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_pend   <= '0;
            for (int k = 0; k < N; k++) begin
                r_count[k] <= '0;
                r_time[k]  <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_op  <= i_operation;
                r_reg <= i_region;
                r_blk <= i_block_number;
                r_now <= i_now_ms;
            end
            if (i_cmd.lookup) begin
                r_hit  <= |w_match;
                r_free <= |w_freev;
                r_slot <= (|w_match) ? w_hit_idx : w_free_idx;
            end
            if (i_cmd.min_pass) r_least <= w_min;
            if (i_cmd.age_pass) r_slot <= w_age_idx;
            if (i_cmd.commit) begin
                o_slot          <= 3'(r_slot);
                o_result_region <= r_reg;
                o_hit           <= r_hit;
                o_fetch_needed  <= !r_hit && !w_wr;
                o_evict_dirty   <= !r_hit && !r_free && r_dirty[w_k];
                o_evicted_block <= (!r_hit && !r_free && r_dirty[w_k]) ? r_tag[w_k] : '0;
                o_disk_write    <= w_wr && i_write_through;
                o_written_block <= (w_wr && i_write_through) ? r_blk : '0;
                o_last          <= 1'b1;
                r_time[w_k]     <= r_now;
                if (r_hit) begin
                    r_count[w_k]   <= r_count[w_k] + 32'd1;
                    o_hits_total   <= r_hits + 32'd1;
                    o_misses_total <= r_misses;
                    r_hits         <= r_hits + 32'd1;
                    if (w_wr) r_dirty[w_k] <= !i_write_through;
                end else begin
                    r_count[w_k]   <= '0;
                    r_tag[w_k]     <= r_blk;
                    r_valid[w_k]   <= 1'b1;
                    r_dirty[w_k]   <= w_wr && !i_write_through;
                    o_hits_total   <= r_hits;
                    o_misses_total <= r_misses + 32'd1;
                    r_misses       <= r_misses + 32'd1;
                end
            end
            if (i_cmd.sync_start) r_pend <= r_valid & r_dirty;
            if (i_cmd.sync_emit) begin
                r_pend[w_dk]    <= 1'b0;
                r_dirty[w_dk]   <= 1'b0;
                // split the flat index into region and slot
                o_slot          <= (w_dk >= KW'(ENTRIES)) ? 3'(w_dk - KW'(ENTRIES)) : 3'(w_dk);
                o_result_region <= w_dk >= KW'(ENTRIES);
                o_hit           <= 1'b0;
                o_fetch_needed  <= 1'b0;
                o_evict_dirty   <= 1'b0;
                o_evicted_block <= '0;
                o_disk_write    <= 1'b1;
                o_written_block <= r_tag[w_dk];
                o_hits_total    <= r_hits;
                o_misses_total  <= r_misses;
                o_last          <= o_sts.dirty_one;
            end
        end
    end

endmodule

// ----- rtl/block_cache_lfu_controller_top.sv -----
// top level of the block cache lfu controller
//
// two fully associative caches (data, system) of ENTRIES slots each; tags
// and lfu policy only, no block data is moved here
// input channel: i_valid / o_stall, one request per transfer (read, write,
// sync); output channel: o_valid / i_stall, one result per transfer
// a hit or a miss with a free slot goes from transfer through the lookup,
// min and commit states to the result; a full-region miss also passes the
// age state, the victim search running as two passes (minimum use count,
// then oldest among those)
// a sync captures its dirty mask, then emits its results one by one, slots
// reported in region then slot order, last marking the final one; a sync
// with nothing dirty or an unknown operation gives no result
// one request is in the block at a time; o_stall is high from transfer until
// its last result has been taken, so a new request is taken only once idle
// while the receiver stalls, the result register holds and the block waits
// reset clears valid, dirty, use counts, time stamps, hit and miss
// counters and write_through; tags need no clearing
// config: apb register 0 at address 0 is write_through
module block_cache_lfu_controller_top
    import bclfu_pkg::*;
#(
    parameter int ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic        i_region,
    input  logic [31:0] i_block_number,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_slot,
    output logic        o_result_region,
    output logic        o_hit,
    output logic        o_fetch_needed,
    output logic        o_evict_dirty,
    output logic [31:0] o_evicted_block,
    output logic        o_disk_write,
    output logic [31:0] o_written_block,
    output logic [31:0] o_hits_total,
    output logic [31:0] o_misses_total,
    output logic        o_last
);

    logic r_write_through;
    t_cmd w_cmd;
    t_sts w_sts;

    // apb: register 0 is write_through, other addresses read zero
    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'd0) ? {31'd0, r_write_through} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_through <= 1'b0;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_write_through <= pwdata[0];
        end
    end

    bclfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (i_stall),
        .i_sts       (w_sts),
        .o_stall     (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    bclfu_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_write_through (r_write_through),
        .i_operation     (i_operation),
        .i_region        (i_region),
        .i_block_number  (i_block_number),
        .i_now_ms        (i_now_ms),
        .o_sts           (w_sts),
        .o_slot          (o_slot),
        .o_result_region (o_result_region),
        .o_hit           (o_hit),
        .o_fetch_needed  (o_fetch_needed),
        .o_evict_dirty   (o_evict_dirty),
        .o_evicted_block (o_evicted_block),
        .o_disk_write    (o_disk_write),
        .o_written_block (o_written_block),
        .o_hits_total    (o_hits_total),
        .o_misses_total  (o_misses_total),
        .o_last          (o_last)
    );

endmodule

// ----- rtl/bclfu_checker.sv -----
// port-level checker for the block cache lfu controller, with its bind
module bclfu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_stall,
    input logic        o_hit,
    input logic        o_fetch_needed,
    input logic        o_evict_dirty,
    input logic        o_disk_write,
    input logic [31:0] o_evicted_block
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");

    a_hit_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_fetch_needed && !o_evict_dirty)
        else $error("hit with fetch or eviction");

    a_evict_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evict_dirty |-> o_evicted_block == 32'd0)
        else $error("evicted block without eviction");

    // a disk write only comes from a write or a sync, never a read miss
    a_write_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_disk_write |-> !o_fetch_needed)
        else $error("disk write together with fetch");

endmodule

bind block_cache_lfu_controller_top bclfu_checker u_bclfu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_stall         (o_stall),
    .o_hit           (o_hit),
    .o_fetch_needed  (o_fetch_needed),
    .o_evict_dirty   (o_evict_dirty),
    .o_disk_write    (o_disk_write),
    .o_evicted_block (o_evicted_block)
);

// ----- tb/tb_block_cache_lfu_controller_top.sv -----
// self-checking testbench for the block cache lfu controller
`timescale 1ns / 1ps

module tb_block_cache_lfu_controller_top;
    import bclfu_pkg::*;

    localparam int SLOTS = 8;
    localparam logic [1:0] OP_BAD = 2'd3;
    localparam logic [1:0] ADDR_WRITE_THROUGH = 2'd0;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  operation;
        logic        region;
        logic [31:0] block_number;
        logic [31:0] now_ms;
    } t_request;

    typedef struct packed {
        logic [2:0]  slot;
        logic        region;
        logic        hit;
        logic        fetch_needed;
        logic        evict_dirty;
        logic [31:0] evicted_block;
        logic        disk_write;
        logic [31:0] written_block;
        logic [31:0] hits_total;
        logic [31:0] misses_total;
        logic        last;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_operation = '0;
    logic i_region = 1'b0;
    logic [31:0] i_block_number = '0;
    logic [31:0] i_now_ms = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [2:0] o_slot;
    logic o_result_region, o_hit, o_fetch_needed, o_evict_dirty;
    logic [31:0] o_evicted_block;
    logic o_disk_write;
    logic [31:0] o_written_block, o_hits_total, o_misses_total;
    logic o_last;

    block_cache_lfu_controller_top u_top (.*);

    always #2 i_clk = ~i_clk;

    // predicted cache state
    logic [31:0] tag_q [2*SLOTS];
    logic        valid_q [2*SLOTS];
    logic        dirty_q [2*SLOTS];
    logic [31:0] uses_q [2*SLOTS];
    logic [31:0] stamp_q [2*SLOTS];
    logic [31:0] hit_tally, miss_count;
    logic        wt_mode;

    t_request pending_requests[$];
    t_outcome expected_outcomes[$];
    int  mismatches = 0;
    bit  timed_out = 0;
    bit  hold_long = 0;     // asks the receiver for a long hold-off
    bit  drain_pause = 0;   // sender holds back while set
    longint cycles = 0;
    int  recent[$];         // block numbers already used, for hits

    function automatic t_outcome make_outcome(int s, bit r, bit h, bit f, bit e,
                                              logic [31:0] eb, bit dw,
                                              logic [31:0] wb, bit l);
        t_outcome o;
        o.slot = s[2:0]; o.region = r; o.hit = h; o.fetch_needed = f;
        o.evict_dirty = e; o.evicted_block = eb; o.disk_write = dw;
        o.written_block = wb; o.hits_total = hit_tally;
        o.misses_total = miss_count; o.last = l;
        return o;
    endfunction

    // applies one accepted request to the predicted state
    task automatic predict_request(t_request q);
        int base, k, s, n;
        logic [31:0] least, age, best_age;
        bit found, wr, ev;
        logic [31:0] evb;
        base = q.region ? SLOTS : 0;
        wr = (q.operation == OP_WRITE);
        if (q.operation == OP_BAD) return;
        if (q.operation == OP_SYNC) begin
            n = 0;
            for (k = 0; k < 2*SLOTS; k++) begin
                if (valid_q[k] && dirty_q[k]) begin
                    dirty_q[k] = 1'b0;
                    expected_outcomes.push_back(make_outcome(k % SLOTS, k >= SLOTS,
                        1'b0, 1'b0, 1'b0, 32'd0, 1'b1, tag_q[k], 1'b0));
                    n++;
                end
            end
            if (n > 0) expected_outcomes[expected_outcomes.size()-1].last = 1'b1;
            return;
        end
        for (k = base; k < base + SLOTS; k++) begin
            if (valid_q[k] && tag_q[k] == q.block_number) begin
                stamp_q[k] = q.now_ms;
                uses_q[k] = uses_q[k] + 32'd1;
                hit_tally = hit_tally + 32'd1;
                if (wr) dirty_q[k] = !wt_mode;
                expected_outcomes.push_back(make_outcome(k - base, q.region, 1'b1, 1'b0,
                    1'b0, 32'd0, wr && wt_mode, (wr && wt_mode) ? q.block_number : 32'd0,
                    1'b1));
                return;
            end
        end
        miss_count = miss_count + 32'd1;
        s = SLOTS; ev = 1'b0; evb = 32'd0;
        for (k = 0; k < SLOTS; k++)
            if (s == SLOTS && !valid_q[base+k]) s = k;
        if (s == SLOTS) begin
            // lowest use count, then oldest, then lowest index
            least = 32'hFFFF_FFFF;
            for (k = 0; k < SLOTS; k++)
                if (uses_q[base+k] < least) least = uses_q[base+k];
            found = 1'b0; best_age = 32'd0; s = 0;
            for (k = 0; k < SLOTS; k++) begin
                if (uses_q[base+k] == least) begin
                    age = q.now_ms - stamp_q[base+k];
                    if (!found || age > best_age) begin
                        found = 1'b1; best_age = age; s = k;
                    end
                end
            end
            if (dirty_q[base+s]) begin
                ev = 1'b1; evb = tag_q[base+s];
            end
        end
        tag_q[base+s] = q.block_number;
        valid_q[base+s] = 1'b1;
        dirty_q[base+s] = wr && !wt_mode;
        uses_q[base+s] = 32'd0;
        stamp_q[base+s] = q.now_ms;
        expected_outcomes.push_back(make_outcome(s, q.region, 1'b0, !wr, ev, evb,
            wr && wt_mode, (wr && wt_mode) ? q.block_number : 32'd0, 1'b1));
    endtask

    // driver: bursts of random length with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            // current item accepted, or nothing offered
            if (i_valid) predict_request({i_operation, i_region, i_block_number, i_now_ms});
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_requests.size() > 0 && !drain_pause) begin
                t_request q;
                q = pending_requests.pop_front();
                i_valid <= 1'b1;
                {i_operation, i_region, i_block_number, i_now_ms} <= q;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with one long hold-off once hold_long is set
    int stall_mode = 0, mode_left = 0, hold_count = 0;
    always @(posedge i_clk) begin
        if (hold_long && hold_count < 300) begin
            hold_count <= hold_count + 1;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(10, 60);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 1) == 0);
                default: i_stall <= (cycles % 5) < 3;
            endcase
        end
    end

    // monitor: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_outcome got, exp_o;
            got = {o_slot, o_result_region, o_hit, o_fetch_needed, o_evict_dirty,
                   o_evicted_block, o_disk_write, o_written_block, o_hits_total,
                   o_misses_total, o_last};
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                exp_o = expected_outcomes.pop_front();
                if (got !== exp_o) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", exp_o, got);
                end
            end
        end
        if (cycles > CYCLE_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("block_cache_lfu_controller_top regression: fail");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        wt_mode = data[0];
    endtask

    task automatic add_request(logic [1:0] op, bit r, logic [31:0] b, logic [31:0] t);
        t_request q;
        q.operation = op; q.region = r; q.block_number = b; q.now_ms = t;
        pending_requests.push_back(q);
        if (op != OP_SYNC && op != OP_BAD) recent.push_back(b);
        if (recent.size() > 24) void'(recent.pop_front());
    endtask

    // wait until the block is idle and every result has come
    task automatic wait_idle();
        while (pending_requests.size() > 0 || i_valid || expected_outcomes.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic add_random(int count);
        int j;
        logic [31:0] clock_ms;
        logic [1:0] op;
        clock_ms = $urandom;
        for (j = 0; j < count; j++) begin
            clock_ms = clock_ms + $urandom_range(0, 50);
            case ($urandom_range(0, 19))
                0: op = OP_SYNC;
                1: op = OP_BAD;
                default: op = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
            endcase
            if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
            if (recent.size() > 0 && $urandom_range(0, 1) == 0)
                add_request(op, 1'($urandom_range(0, 1)),
                            recent[$urandom_range(0, recent.size()-1)], clock_ms);
            else if ($urandom_range(0, 1) == 0)
                add_request(op, 1'($urandom_range(0, 1)), $urandom_range(0, 30), clock_ms);
            else
                add_request(op, 1'($urandom_range(0, 1)), $urandom, clock_ms);
        end
    endtask

    initial begin
        int j;
        for (j = 0; j < 2*SLOTS; j++) begin
            tag_q[j] = 0; valid_q[j] = 0; dirty_q[j] = 0; uses_q[j] = 0; stamp_q[j] = 0;
        end
        hit_tally = 0; miss_count = 0; wt_mode = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_write(ADDR_WRITE_THROUGH, 32'd0);

        // directed: fill the data cache with writes, hits, eviction of dirty
        // victims with age wrap, empty sync, unknown operation, extreme fields
        add_request(OP_SYNC, 0, 0, 0);
        add_request(OP_BAD, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (j = 0; j < SLOTS; j++)
            add_request(OP_WRITE, 0, (j == 7) ? 32'hFFFF_FFFF : j, 32'hFFFF_FFF0 + j);
        add_request(OP_READ, 0, 3, 32'd5);
        add_request(OP_READ, 0, 32'hFFFF_FFFF, 32'd6);
        add_request(OP_READ, 0, 100, 32'd7);           // evicts oldest unused
        add_request(OP_WRITE, 0, 101, 32'd7);          // write miss at the same time stamp, evicts the oldest unused
        add_request(OP_READ, 1, 32'hFFFF_FFFF, 32'h0); // system cache
        add_request(OP_WRITE, 1, 0, 32'h0);
        add_request(OP_SYNC, 1, 0, 32'd9);
        add_request(OP_SYNC, 0, 0, 32'd10);
        wait_idle();

        apb_write(ADDR_WRITE_THROUGH, 32'hFFFF_FFFF);
        add_request(OP_WRITE, 0, 3, 32'd20);
        add_request(OP_WRITE, 1, 77, 32'd21);
        add_random(50);
        wait_idle();

        // long receiver hold-off while the sender keeps offering
        apb_write(ADDR_WRITE_THROUGH, 32'd0);
        add_random(40);
        hold_long = 1;
        wait_idle();

        // sender pauses part way until every result has come
        add_random(30);
        while (pending_requests.size() > 15) @(posedge i_clk);
        drain_pause = 1;
        while (i_valid || expected_outcomes.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        drain_pause = 0;
        add_random(20);
        wait_idle();

        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("block_cache_lfu_controller_top regression: pass");
        else
            $display("block_cache_lfu_controller_top regression: fail");
        $finish;
    end

endmodule
